FILE: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside of reset.
`define DRPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every clock edge, including those in reset.
`define DRPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: src/drpt_pkg.sv
// Types, constants and helpers of the DMA ring pointer tracker.
`timescale 1ns / 1ps
package drpt_pkg;

  localparam int PTR_BITS    = 26;
  localparam int SIZE_W      = PTR_BITS + 1;
  localparam int RING_W      = 27;
  localparam int BURST_W     = 24;
  localparam int MINRDY_W    = 27;
  localparam int ADDR_W      = 32;
  localparam int XFER_W      = 26;
  localparam int CONSUME_W   = 19;
  localparam int SPAN_W      = 19;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [SPAN_W-1:0] READ_CLAMP = SPAN_W'(32'h100000 / 4);
  localparam logic [SIZE_W-1:0] RING_LIM   = SIZE_W'(1) << PTR_BITS;

  // Request codes.
  localparam logic [1:0] REQ_XFER_DONE = 2'd0;
  localparam logic [1:0] REQ_CONSUME   = 2'd1;
  localparam logic [1:0] REQ_OVERFLOW  = 2'd2;
  localparam logic [1:0] REQ_RESTART   = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RING_WORDS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_WORDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_READY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_BASE    = 2'd3;

  typedef struct packed {
    logic [RING_W-1:0]   ring_words;
    logic [BURST_W-1:0]  burst_words;
    logic [MINRDY_W-1:0] min_ready_words;
    logic [ADDR_W-1:0]   ring_base;
  } drpt_cfg_t;

  typedef struct packed {
    logic [PTR_BITS-1:0] wr_ptr;
    logic [PTR_BITS-1:0] rd_ptr;
    logic                wr_lap;
    logic                rd_lap;
    logic                stop;
  } drpt_state_t;

  typedef struct packed {
    logic [PTR_BITS-1:0] write_offset;
    logic [PTR_BITS-1:0] read_offset;
    logic [ADDR_W-1:0]   dest_address;
    logic [XFER_W-1:0]   transfer_bytes;
    logic [PTR_BITS-1:0] fill_words;
    logic                enough_data;
    logic                ring_full;
    logic [SPAN_W-1:0]   readable_words;
    logic                stopped;
  } drpt_result_t;

  // Ring size as used by the pointer math: zero means one word, and anything
  // above the pointer range saturates to it.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [RING_W-1:0] ring_words);
    logic [SIZE_W-1:0] sz;
    sz = SIZE_W'(ring_words);
    if (ring_words == '0) begin
      return SIZE_W'(1);
    end else if (sz > RING_LIM) begin
      return RING_LIM;
    end
    return sz;
  endfunction

endpackage

FILE: src/drpt_if.sv
// Handshake interfaces of the input, result and configuration channels.
`timescale 1ns / 1ps
interface drpt_in_if;
  import drpt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [CONSUME_W-1:0] consume_words;
  modport source (output valid, output req_type, output consume_words, input ready);
  modport sink   (input valid, input req_type, input consume_words, output ready);
endinterface

interface drpt_out_if;
  import drpt_pkg::*;
  logic                valid;
  logic                ready;
  logic [PTR_BITS-1:0] write_offset;
  logic [PTR_BITS-1:0] read_offset;
  logic [ADDR_W-1:0]   dest_address;
  logic [XFER_W-1:0]   transfer_bytes;
  logic [PTR_BITS-1:0] fill_words;
  logic                enough_data;
  logic                ring_full;
  logic [SPAN_W-1:0]   readable_words;
  logic                stopped;
  modport source (output valid, output write_offset, output read_offset,
                  output dest_address, output transfer_bytes, output fill_words,
                  output enough_data, output ring_full, output readable_words,
                  output stopped, input ready);
  modport sink   (input valid, input write_offset, input read_offset,
                  input dest_address, input transfer_bytes, input fill_words,
                  input enough_data, input ring_full, input readable_words,
                  input stopped, output ready);
endinterface

interface drpt_cfg_if;
  import drpt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/drpt_state_upd.sv
// Pointer, lap and stop registers with their per-event update.
`timescale 1ns / 1ps
module drpt_state_upd (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ev_vld,
  input  logic [1:0]           req_type,
  input  logic [drpt_pkg::CONSUME_W-1:0] consume_words,
  input  drpt_pkg::drpt_cfg_t  cfg,
  output drpt_pkg::drpt_state_t st
);
  import drpt_pkg::*;

  drpt_state_t       st_r;
  drpt_state_t       st_nxt;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] wr_sum;
  logic [SIZE_W-1:0] rd_sum;

  assign size   = eff_size(cfg.ring_words);
  assign wr_sum = SIZE_W'(st_r.wr_ptr) + SIZE_W'(cfg.burst_words);
  assign rd_sum = SIZE_W'(st_r.rd_ptr) + SIZE_W'(consume_words);

  always_comb begin
    st_nxt = st_r;
    if (ev_vld) begin
      case (req_type)
        REQ_XFER_DONE: begin
          if (!st_r.stop) begin
            if (wr_sum >= size) begin
              st_nxt.wr_ptr = '0;
              st_nxt.wr_lap = ~st_r.wr_lap;
            end else begin
              st_nxt.wr_ptr = wr_sum[PTR_BITS-1:0];
            end
          end
        end
        REQ_CONSUME: begin
          if (rd_sum >= size) begin
            st_nxt.rd_ptr = '0;
            st_nxt.rd_lap = ~st_r.rd_lap;
          end else begin
            st_nxt.rd_ptr = rd_sum[PTR_BITS-1:0];
          end
        end
        REQ_OVERFLOW: begin
          st_nxt.stop = 1'b1;
        end
        REQ_RESTART: begin
          // Lap bits survive a restart.
          st_nxt.wr_ptr = '0;
          st_nxt.rd_ptr = '0;
          st_nxt.stop   = 1'b0;
        end
        default: begin
          st_nxt = st_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st = st_r;

endmodule

FILE: src/drpt_status.sv
// Status math on the current pointers and the result register.
`timescale 1ns / 1ps
module drpt_status (
  input  logic                  clk,
  input  logic                  load,
  input  drpt_pkg::drpt_state_t st,
  input  drpt_pkg::drpt_cfg_t   cfg,
  output drpt_pkg::drpt_result_t res
);
  import drpt_pkg::*;

  drpt_result_t        res_r;
  drpt_result_t        res_nxt;
  logic [SIZE_W-1:0]   size;
  logic [SIZE_W-1:0]   rd_ext;
  logic [SIZE_W-1:0]   span;
  logic [SIZE_W-1:0]   reach;
  logic [PTR_BITS-1:0] fill;

  assign size   = eff_size(cfg.ring_words);
  assign rd_ext = SIZE_W'(st.rd_ptr);
  assign reach  = SIZE_W'(st.wr_ptr) + SIZE_W'(cfg.burst_words);

  always_comb begin
    // Past the wrap the distance is taken modulo the pointer range, which also
    // covers a read offset left beyond a shrunk ring.
    if (st.rd_ptr <= st.wr_ptr) begin
      fill = st.wr_ptr - st.rd_ptr;
    end else begin
      fill = size[PTR_BITS-1:0] - st.rd_ptr + st.wr_ptr;
    end

    if (st.wr_ptr > st.rd_ptr) begin
      span = SIZE_W'(st.wr_ptr - st.rd_ptr);
    end else if (size > rd_ext) begin
      span = size - rd_ext;
    end else begin
      span = '0;
    end

    res_nxt.write_offset   = st.wr_ptr;
    res_nxt.read_offset    = st.rd_ptr;
    res_nxt.dest_address   = cfg.ring_base + ADDR_W'({st.wr_ptr, 2'b00});
    res_nxt.transfer_bytes = XFER_W'({cfg.burst_words, 2'b00});
    res_nxt.fill_words     = fill;
    res_nxt.enough_data    = MINRDY_W'(fill) >= cfg.min_ready_words;
    res_nxt.ring_full      = st.stop || ((st.wr_lap != st.rd_lap) && (reach > rd_ext));
    res_nxt.readable_words = (span > SIZE_W'(READ_CLAMP)) ? READ_CLAMP : span[SPAN_W-1:0];
    res_nxt.stopped        = st.stop;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: src/dma_ring_pointer_tracker_top.sv
// Top level of the DMA ring pointer tracker.
`timescale 1ns / 1ps
// Tracks write and read offsets of a DRAM ring filled by a stream-to-memory DMA.
// in_ch carries one event per transfer: transfer done, consume (with a word
// count), overflow or restart. out_ch returns one status transfer per event:
// offsets, next destination address and burst length, fill level, enough-data
// and full flags, readable span and the stop flag, all after the event.
// cfg_ch writes the ring size, burst length, fill threshold and base address;
// it is always ready. The user must write it only while no event is in flight;
// the block itself does not enforce this. An accepted event updates the pointer
// registers at that edge; the status is computed from them and registered in
// the result register. One event per cycle is sustained while out_ch does not
// stall, set by the single add and compare of the pointer update.
// When out_ch stalls, one further event is held in the pointer stage and
// in_ch.ready drops until the result register is emptied.
// Reset (rst_n low, synchronous) clears both offsets, both lap bits and the
// stop flag, empties the pipeline and restores the register defaults.
module dma_ring_pointer_tracker_top (
  input  logic      clk,
  input  logic      rst_n,
  drpt_in_if.sink   in_ch,
  drpt_out_if.source out_ch,
  drpt_cfg_if.sink  cfg_ch
);
  import drpt_pkg::*;

  drpt_cfg_t    cfg_r;
  drpt_cfg_t    cfg_nxt;
  drpt_state_t  st;
  drpt_result_t res;
  logic         in_acc;
  logic         st_vld_r;
  logic         st_vld_nxt;
  logic         out_vld_r;
  logic         out_vld_nxt;
  logic         st_adv;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_RING_WORDS:  cfg_nxt.ring_words      = cfg_ch.data[RING_W-1:0];
        REG_BURST_WORDS: cfg_nxt.burst_words     = cfg_ch.data[BURST_W-1:0];
        REG_MIN_READY:   cfg_nxt.min_ready_words = cfg_ch.data[MINRDY_W-1:0];
        REG_MEM_BASE:    cfg_nxt.ring_base       = cfg_ch.data[ADDR_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // The pointer stage hands its status on whenever the result register is
  // empty or being emptied.
  assign st_adv      = st_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !st_vld_r || st_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign st_vld_nxt  = in_acc || (st_vld_r && !st_adv);
  assign out_vld_nxt = st_adv || (out_vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_words      <= RING_W'(67108864);
      cfg_r.burst_words     <= BURST_W'(1024);
      cfg_r.min_ready_words <= MINRDY_W'(1024);
      cfg_r.ring_base       <= '0;
      st_vld_r              <= 1'b0;
      out_vld_r             <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      st_vld_r  <= st_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  drpt_state_upd u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .ev_vld        (in_acc),
    .req_type      (in_ch.req_type),
    .consume_words (in_ch.consume_words),
    .cfg           (cfg_r),
    .st            (st)
  );

  drpt_status u_status (
    .clk  (clk),
    .load (st_adv),
    .st   (st),
    .cfg  (cfg_r),
    .res  (res)
  );

  assign out_ch.valid          = out_vld_r;
  assign out_ch.write_offset   = res.write_offset;
  assign out_ch.read_offset    = res.read_offset;
  assign out_ch.dest_address   = res.dest_address;
  assign out_ch.transfer_bytes = res.transfer_bytes;
  assign out_ch.fill_words     = res.fill_words;
  assign out_ch.enough_data    = res.enough_data;
  assign out_ch.ring_full      = res.ring_full;
  assign out_ch.readable_words = res.readable_words;
  assign out_ch.stopped        = res.stopped;

endmodule

FILE: src/drpt_checker.sv
// Port-level assertions of the DMA ring pointer tracker and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module drpt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [drpt_pkg::PTR_BITS-1:0] out_write_offset,
  input logic                          out_ring_full,
  input logic                          out_stopped,
  input logic [drpt_pkg::SPAN_W-1:0]   out_readable_words
);
  import drpt_pkg::*;

  // A stalled result stays offered with its write offset unchanged.
  `DRPT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_write_offset), "stalled result dropped or changed")

  // Nothing is offered right after a reset cycle.
  `DRPT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result offered after reset")

  // A stopped ring always reports full.
  `DRPT_ASSERT(a_stop_full, clk, rst_n, out_valid && out_stopped |-> out_ring_full, "stopped ring not reported full")

  // The readable span never exceeds the clamp.
  `DRPT_ASSERT(a_span_clamp, clk, rst_n, out_valid |-> out_readable_words <= READ_CLAMP, "readable span above clamp")

endmodule

bind dma_ring_pointer_tracker_top drpt_checker u_drpt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_write_offset   (out_ch.write_offset),
  .out_ring_full      (out_ch.ring_full),
  .out_stopped        (out_ch.stopped),
  .out_readable_words (out_ch.readable_words)
);

FILE: bench/testbench.sv
// Self-checking testbench of the DMA ring pointer tracker: directed table, then random phases.
`timescale 1ns / 1ps
module testbench;
  import drpt_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 150;
  localparam logic [63:0] RING_CAP    = 64'd1 << PTR_BITS;
  localparam logic [63:0] POS_MASK    = RING_CAP - 64'd1;

  typedef struct {
    bit                is_cfg;
    logic [1:0]        code;
    logic [31:0]       value;
    bit                typed;
    drpt_result_t      want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic [1:0]            in_req = REQ_XFER_DONE;
  logic [CONSUME_W-1:0]  in_cw = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_RING_WORDS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  drpt_in_if  in_if ();
  drpt_out_if out_if ();
  drpt_cfg_if cfg_if ();

  assign in_if.valid         = in_valid;
  assign in_if.req_type      = in_req;
  assign in_if.consume_words = in_cw;
  assign out_if.ready        = out_ready;
  assign cfg_if.valid        = cfg_valid;
  assign cfg_if.index        = cfg_idx;
  assign cfg_if.data         = cfg_data;

  dma_ring_pointer_tracker_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  // Shadow copy of the tracker state and its registers.
  logic [PTR_BITS-1:0] wr_pos = '0;
  logic [PTR_BITS-1:0] rd_pos = '0;
  logic                wr_lap_q = 1'b0;
  logic                rd_lap_q = 1'b0;
  logic                stop_q = 1'b0;
  logic [RING_W-1:0]   cfg_ring = 27'd67108864;
  logic [BURST_W-1:0]  cfg_burst = 24'd1024;
  logic [MINRDY_W-1:0] cfg_min_ready = 27'd1024;
  logic [ADDR_W-1:0]   cfg_base = '0;

  drpt_result_t pending_status[$];
  stim_row_t    script[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;

  task automatic advance_pointers(input logic [1:0] req, input logic [CONSUME_W-1:0] cw,
                                  output drpt_result_t status);
    logic [63:0] size;
    logic [63:0] sum;
    logic [63:0] fill;
    logic [63:0] span;
    if (cfg_ring == '0) begin
      size = 64'd1;
    end else if (64'(cfg_ring) > RING_CAP) begin
      size = RING_CAP;
    end else begin
      size = 64'(cfg_ring);
    end
    case (req)
      REQ_XFER_DONE: begin
        if (!stop_q) begin
          sum = 64'(wr_pos) + 64'(cfg_burst);
          if (sum >= size) begin
            sum = '0;
            wr_lap_q = ~wr_lap_q;
          end
          wr_pos = sum[PTR_BITS-1:0];
        end
      end
      REQ_CONSUME: begin
        sum = 64'(rd_pos) + 64'(cw);
        if (sum >= size) begin
          sum = '0;
          rd_lap_q = ~rd_lap_q;
        end
        rd_pos = sum[PTR_BITS-1:0];
      end
      REQ_OVERFLOW: stop_q = 1'b1;
      default: begin
        wr_pos = '0;
        rd_pos = '0;
        stop_q = 1'b0;
      end
    endcase
    // A pointer left beyond a shrunk ring makes the distance wrap modulo the pointer range.
    if (rd_pos <= wr_pos) begin
      fill = 64'(wr_pos) - 64'(rd_pos);
    end else begin
      fill = (size - 64'(rd_pos) + 64'(wr_pos)) & POS_MASK;
    end
    if (wr_pos > rd_pos) begin
      span = 64'(wr_pos) - 64'(rd_pos);
    end else if (size > 64'(rd_pos)) begin
      span = size - 64'(rd_pos);
    end else begin
      span = '0;
    end
    if (span > 64'(READ_CLAMP)) begin
      span = 64'(READ_CLAMP);
    end
    status.write_offset   = wr_pos;
    status.read_offset    = rd_pos;
    status.dest_address   = cfg_base + 32'({wr_pos, 2'b00});
    status.transfer_bytes = {cfg_burst, 2'b00};
    status.fill_words     = fill[PTR_BITS-1:0];
    status.enough_data    = (fill >= 64'(cfg_min_ready));
    status.ring_full      = stop_q ||
                            ((wr_lap_q != rd_lap_q) &&
                             (64'(wr_pos) + 64'(cfg_burst) > 64'(rd_pos)));
    status.readable_words = span[SPAN_W-1:0];
    status.stopped        = stop_q;
  endtask

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] data);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.code   = idx;
    row.value  = data;
    row.typed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic stim_row_t evt_row(input logic [1:0] req, input logic [18:0] cw);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.code   = req;
    row.value  = 32'(cw);
    row.typed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic stim_row_t chk_row(input logic [1:0] req, input logic [18:0] cw,
                                        input logic [25:0] wo, input logic [25:0] ro,
                                        input logic [31:0] dest, input logic [25:0] bytes,
                                        input logic [25:0] fill, input logic enough,
                                        input logic full, input logic [18:0] span,
                                        input logic stopped);
    stim_row_t row;
    row       = evt_row(req, cw);
    row.typed = 1'b1;
    row.want  = {wo, ro, dest, bytes, fill, enough, full, span, stopped};
    return row;
  endfunction

  task automatic send_event(input logic [1:0] req, input logic [CONSUME_W-1:0] cw,
                            input bit typed, input drpt_result_t want);
    drpt_result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    in_cw    <= cw;
    do @(posedge clk); while (!in_if.ready);
    advance_pointers(req, cw, predicted);
    pending_status.push_back(typed ? want : predicted);
  endtask

  // Registers change only with the pipeline drained.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RING_WORDS:  cfg_ring      = data[RING_W-1:0];
      REG_BURST_WORDS: cfg_burst     = data[BURST_W-1:0];
      REG_MIN_READY:   cfg_min_ready = data[MINRDY_W-1:0];
      default:         cfg_base      = data;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    drpt_result_t want;
    if (rst_n && out_if.valid && out_ready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: status transfer with nothing pending, expected none, actual %0h",
                 $time, out_if.write_offset);
      end else begin
        want = pending_status.pop_front();
        check_field("write_offset", 32'(want.write_offset), 32'(out_if.write_offset));
        check_field("read_offset", 32'(want.read_offset), 32'(out_if.read_offset));
        check_field("dest_address", want.dest_address, out_if.dest_address);
        check_field("transfer_bytes", 32'(want.transfer_bytes), 32'(out_if.transfer_bytes));
        check_field("fill_words", 32'(want.fill_words), 32'(out_if.fill_words));
        check_field("enough_data", 32'(want.enough_data), 32'(out_if.enough_data));
        check_field("ring_full", 32'(want.ring_full), 32'(out_if.ring_full));
        check_field("readable_words", 32'(want.readable_words), 32'(out_if.readable_words));
        check_field("stopped", 32'(want.stopped), 32'(out_if.stopped));
      end
    end
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [1:0]           req;
    logic [CONSUME_W-1:0] cw;
    int                   hint;
    int                   pick;

    // Reset defaults: ring of 2^26 words, bursts of 1024, threshold 1024, base 0.
    script.push_back(chk_row(REQ_XFER_DONE, 0, 1024, 0, 4096, 4096, 1024, 1, 0, 1024, 0));
    script.push_back(chk_row(REQ_CONSUME, 1024, 1024, 1024, 4096, 4096, 0, 0, 0, 262144, 0));
    script.push_back(chk_row(REQ_OVERFLOW, 0, 1024, 1024, 4096, 4096, 0, 0, 1, 262144, 1));
    script.push_back(chk_row(REQ_XFER_DONE, 0, 1024, 1024, 4096, 4096, 0, 0, 1, 262144, 1));
    script.push_back(evt_row(REQ_CONSUME, 19'h7FFFF));
    script.push_back(chk_row(REQ_RESTART, 0, 0, 0, 0, 4096, 0, 0, 0, 262144, 0));
    // Tiny ring: wraps on both sides, equal offsets with different laps, address wrap.
    script.push_back(cfg_row(REG_RING_WORDS, 32'd8));
    script.push_back(cfg_row(REG_BURST_WORDS, 32'd3));
    script.push_back(cfg_row(REG_MIN_READY, 32'd2));
    script.push_back(cfg_row(REG_MEM_BASE, 32'hFFFF_FFF0));
    repeat (3) script.push_back(evt_row(REQ_XFER_DONE, 0));
    script.push_back(evt_row(REQ_CONSUME, 8));
    script.push_back(evt_row(REQ_CONSUME, 5));
    script.push_back(evt_row(REQ_XFER_DONE, 0));
    // Zero ring size acts as one word; zero burst length.
    script.push_back(cfg_row(REG_RING_WORDS, 32'd0));
    script.push_back(cfg_row(REG_BURST_WORDS, 32'd0));
    script.push_back(cfg_row(REG_MIN_READY, 32'd0));
    script.push_back(evt_row(REQ_XFER_DONE, 0));
    script.push_back(evt_row(REQ_CONSUME, 0));
    // Ring shrunk below both pointers.
    script.push_back(cfg_row(REG_RING_WORDS, 32'd64));
    script.push_back(cfg_row(REG_BURST_WORDS, 32'd40));
    script.push_back(evt_row(REQ_XFER_DONE, 0));
    script.push_back(evt_row(REQ_CONSUME, 50));
    script.push_back(cfg_row(REG_RING_WORDS, 32'd16));
    script.push_back(evt_row(REQ_OVERFLOW, 0));
    script.push_back(evt_row(REQ_CONSUME, 0));
    // Oversized ring saturates; largest burst and base, and a threshold above any fill level.
    script.push_back(cfg_row(REG_RING_WORDS, 32'hFFFF_FFFF));
    script.push_back(cfg_row(REG_BURST_WORDS, 32'hFFFF_FFFF));
    script.push_back(cfg_row(REG_MIN_READY, 32'h0400_0000));
    script.push_back(cfg_row(REG_MEM_BASE, 32'hFFFF_FFFF));
    script.push_back(evt_row(REQ_RESTART, 0));
    repeat (5) script.push_back(evt_row(REQ_XFER_DONE, 0));
    script.push_back(evt_row(REQ_CONSUME, 19'd262144));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_reg(script[i].code, script[i].value);
      end else begin
        send_event(script[i].code, script[i].value[CONSUME_W-1:0], script[i].typed,
                   script[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 74;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 74;
        end
        default: begin
          tx_idle_pct  = 12;
          rx_stall_pct = 12;
        end
      endcase

      pick = $urandom_range(0, 9);
      case (pick)
        0:       write_reg(REG_RING_WORDS, 32'd0);
        1:       write_reg(REG_RING_WORDS, 32'h0400_0000);
        2:       write_reg(REG_RING_WORDS, 32'hFFFF_FFFF);
        3:       write_reg(REG_RING_WORDS, $urandom);
        default: write_reg(REG_RING_WORDS, $urandom_range(1, 64));
      endcase
      hint = (cfg_ring == '0) ? 1 : (cfg_ring > 64) ? 64 : int'(cfg_ring);
      pick = $urandom_range(0, 9);
      case (pick)
        0:       write_reg(REG_BURST_WORDS, 32'd0);
        1:       write_reg(REG_BURST_WORDS, $urandom);
        2:       write_reg(REG_BURST_WORDS, 32'h00FF_FFFF);
        default: write_reg(REG_BURST_WORDS, $urandom_range(1, hint));
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0:       write_reg(REG_MIN_READY, 32'd0);
        1:       write_reg(REG_MIN_READY, $urandom);
        2:       write_reg(REG_MIN_READY, 32'h0400_0000);
        default: write_reg(REG_MIN_READY, $urandom_range(0, hint + 2));
      endcase
      write_reg(REG_MEM_BASE, $urandom);

      repeat (PHASE_ITEMS) begin
        // Now and then hold off until every status transfer has drained.
        if ($urandom_range(0, 63) == 0) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_status.size() != 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          req = REQ_XFER_DONE;
        end else if (pick < 88) begin
          req = REQ_CONSUME;
        end else if (pick < 93) begin
          req = REQ_OVERFLOW;
        end else begin
          req = REQ_RESTART;
        end
        pick = $urandom_range(0, 9);
        case (pick)
          0:       cw = '0;
          1:       cw = '1;
          2:       cw = CONSUME_W'($urandom);
          3:       cw = CONSUME_W'($urandom_range(0, 262144));
          default: cw = CONSUME_W'($urandom_range(0, hint + 2));
        endcase
        send_event(req, cw, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
